/* rtl/sll_pkg.sv */
// Shared types, constants and arithmetic helpers for the stereo look-ahead limiter.
`default_nettype none
package sll_pkg;

    localparam int SAMPLE_BITS     = 24;
    localparam int INT_BITS        = SAMPLE_BITS + 8;
    localparam int GAIN_BITS       = 24;
    localparam int DELAY_DEPTH_DEF = 256;
    localparam int DIV_BITS        = GAIN_BITS + SAMPLE_BITS - 1;
    localparam int DIV_CNT_BITS    = $clog2(DIV_BITS);

    localparam logic [GAIN_BITS-1:0] UNITY_GAIN = 24'd65536;
    localparam logic [GAIN_BITS-1:0] GAIN_FLOOR = 24'd655;
    localparam logic [20:0]          DC_LEAK    = 21'd1288490;
    localparam logic [24:0]          RAMP_ONE   = 25'h1000000;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_THRESHOLD = 3'd0;
    localparam logic [2:0] REG_PREAMP    = 3'd1;
    localparam logic [2:0] REG_POSTAMP   = 3'd2;
    localparam logic [2:0] REG_RECOVER   = 3'd3;
    localparam logic [2:0] REG_LOOKAHEAD = 3'd4;
    localparam logic [2:0] REG_RECIP     = 3'd5;
    localparam logic [2:0] REG_MODE      = 3'd6;

    // mode bit positions
    localparam int MODE_LINEAR = 0;
    localparam int MODE_DC_OFF = 1;
    localparam int MODE_BYPASS = 2;
    localparam int MODE_MUTE   = 3;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_in;
        logic signed [SAMPLE_BITS-1:0] right_in;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] left_out;
        logic signed [SAMPLE_BITS-1:0] right_out;
        logic [GAIN_BITS-1:0]          applied_gain;
    } t_out_item;

    typedef struct packed {
        logic [23:0] threshold;
        logic [23:0] preamp_gain;
        logic [23:0] postamp_gain;
        logic [31:0] recover_step;
        logic [7:0]  lookahead;
        logic [24:0] recip_step;
        logic [3:0]  mode_bits;
    } t_cfg;

    typedef enum logic [3:0] {
        OP_NONE, OP_CLR, OP_PRE, OP_DC, OP_POST, OP_GAIN, OP_TEST, OP_DIV,
        OP_SPAN, OP_WA, OP_WB, OP_WC, OP_RDLAST, OP_RDOUT, OP_MULOUT, OP_BYP
    } t_op;

    typedef struct packed {
        t_op  op;
        logic accept;
    } t_dp_cmd;

    typedef struct packed {
        logic mute;
        logic bypass;
        logic trigger;
        logic walk_on;
        logic div_last;
        logic walk_end;
        logic clr_last;
        logic out_free;
    } t_dp_stat;

    // floor((v + 2^15) / 2^16)
    function automatic logic signed [63:0] rnd_shr16(input logic signed [63:0] v);
        rnd_shr16 = (v + 64'sd32768) >>> 16;
    endfunction

    // floor((v + 2^31) / 2^32)
    function automatic logic signed [63:0] rnd_shr32(input logic signed [63:0] v);
        rnd_shr32 = (v + 64'sd2147483648) >>> 32;
    endfunction

    function automatic logic signed [INT_BITS-1:0] sat_int(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (INT_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            sat_int = hi[INT_BITS-1:0];
        end else if (v < lo) begin
            sat_int = lo[INT_BITS-1:0];
        end else begin
            sat_int = v[INT_BITS-1:0];
        end
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] sat_smp(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi) begin
            sat_smp = hi[SAMPLE_BITS-1:0];
        end else if (v < lo) begin
            sat_smp = lo[SAMPLE_BITS-1:0];
        end else begin
            sat_smp = v[SAMPLE_BITS-1:0];
        end
    endfunction

endpackage
`default_nettype wire

/* rtl/stereo_lookahead_limiter_unit.sv */
// Top level of the linked-stereo look-ahead peak limiter.
// Steps from input transfer to result: pre-gain, DC blocker, post-gain, gain, test, read-out;
//   when limiting starts, the restoring divider, one span step and a read/multiply/compare pass
//   per gain entry the walk visits (at most lookahead) come before the read-out. Bypass/mute
//   skip them all. One pair at a time; a waiting result holds the last step.
// Reset: synchronous, active low; then a clearing pass over all DELAY_DEPTH entries fills the
//   RAMs (delay zero, gain unity) before the first input transfer. APB writes work throughout.
`default_nettype none
module stereo_lookahead_limiter_unit #(
    parameter int DELAY_DEPTH = sll_pkg::DELAY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input sample channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  sll_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sll_pkg::t_out_item o_out_data,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import sll_pkg::*;

    t_cfg     cfg;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // register bank; software must write it only while no pair is in work (not enforced here)
    sll_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // sequencer: clear pass, then per pair the gain, walk and read-out steps
    sll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath with delay and gain RAMs and the output register
    sll_dp #(.DEPTH(DELAY_DEPTH)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd       (cmd),
        .i_in_data   (i_in_data),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // one pair at a time: an input transfer closes the input side for the next cycle
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while a pair is in work");

    // a new result only appears as the end of a pair's work
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result raised without a pair in work");

    // the clearing pass ends before any result
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");
endmodule
`default_nettype wire

/* rtl/sll_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sll_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

/* rtl/sll_regs.sv */
// APB configuration register bank.
`default_nettype none
module sll_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    output sll_pkg::t_cfg o_cfg
);
    import sll_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] idx;
    logic       wr;

    assign idx    = paddr[4:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.threshold    <= 24'd65536;
            r_cfg.preamp_gain  <= 24'd65536;
            r_cfg.postamp_gain <= 24'd65536;
            r_cfg.recover_step <= 32'd63258;
            r_cfg.lookahead    <= 8'd100;
            r_cfg.recip_step   <= 25'd167772;
            r_cfg.mode_bits    <= 4'd0;
        end else if (wr) begin
            unique case (idx)
                REG_THRESHOLD: r_cfg.threshold    <= pwdata[23:0];
                REG_PREAMP:    r_cfg.preamp_gain  <= pwdata[23:0];
                REG_POSTAMP:   r_cfg.postamp_gain <= pwdata[23:0];
                REG_RECOVER:   r_cfg.recover_step <= pwdata;
                REG_LOOKAHEAD: r_cfg.lookahead    <= pwdata[7:0];
                REG_RECIP:     r_cfg.recip_step   <= pwdata[24:0];
                REG_MODE:      r_cfg.mode_bits    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_THRESHOLD: prdata = {8'd0, r_cfg.threshold};
            REG_PREAMP:    prdata = {8'd0, r_cfg.preamp_gain};
            REG_POSTAMP:   prdata = {8'd0, r_cfg.postamp_gain};
            REG_RECOVER:   prdata = r_cfg.recover_step;
            REG_LOOKAHEAD: prdata = {24'd0, r_cfg.lookahead};
            REG_RECIP:     prdata = {7'd0, r_cfg.recip_step};
            REG_MODE:      prdata = {28'd0, r_cfg.mode_bits};
            default:       prdata = 32'd0;
        endcase
    end
endmodule
`default_nettype wire

/* rtl/sll_ctrl.sv */
// Sequencer for the limiter: walks each item through the datapath steps.
`default_nettype none
module sll_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sll_pkg::t_dp_stat i_stat,
    output sll_pkg::t_dp_cmd  o_cmd
);
    import sll_pkg::*;

    typedef enum logic [3:0] {
        ST_CLR, ST_IDLE, ST_PRE, ST_DC, ST_POST, ST_GAIN, ST_TEST, ST_DIV,
        ST_SPAN, ST_WA, ST_WB, ST_WC, ST_RDLAST, ST_RDOUT, ST_MULOUT, ST_BYP
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign accept       = o_in_ready && i_in_valid;
    assign o_cmd.accept = accept;

    always_comb begin
        unique case (r_state)
            ST_CLR:    o_cmd.op = OP_CLR;
            ST_IDLE:   o_cmd.op = OP_NONE;
            ST_PRE:    o_cmd.op = OP_PRE;
            ST_DC:     o_cmd.op = OP_DC;
            ST_POST:   o_cmd.op = OP_POST;
            ST_GAIN:   o_cmd.op = OP_GAIN;
            ST_TEST:   o_cmd.op = OP_TEST;
            ST_DIV:    o_cmd.op = OP_DIV;
            ST_SPAN:   o_cmd.op = OP_SPAN;
            ST_WA:     o_cmd.op = OP_WA;
            ST_WB:     o_cmd.op = OP_WB;
            ST_WC:     o_cmd.op = OP_WC;
            ST_RDLAST: o_cmd.op = OP_RDLAST;
            ST_RDOUT:  o_cmd.op = OP_RDOUT;
            ST_MULOUT: o_cmd.op = OP_MULOUT;
            ST_BYP:    o_cmd.op = OP_BYP;
            default:   o_cmd.op = OP_NONE;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLR:    if (i_stat.clr_last) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    n_state = (i_stat.mute || i_stat.bypass) ? ST_BYP : ST_PRE;
                end
            end
            ST_PRE:    n_state = ST_DC;
            ST_DC:     n_state = ST_POST;
            ST_POST:   n_state = ST_GAIN;
            ST_GAIN:   n_state = ST_TEST;
            ST_TEST:   n_state = (i_stat.trigger && i_stat.walk_on) ? ST_DIV : ST_RDLAST;
            ST_DIV:    if (i_stat.div_last) n_state = ST_SPAN;
            ST_SPAN:   n_state = ST_WA;
            ST_WA:     n_state = ST_WB;
            ST_WB:     n_state = ST_WC;
            ST_WC:     n_state = i_stat.walk_end ? ST_RDLAST : ST_WA;
            ST_RDLAST: n_state = ST_RDOUT;
            ST_RDOUT:  n_state = ST_MULOUT;
            ST_MULOUT: if (i_stat.out_free) n_state = ST_IDLE;
            ST_BYP:    if (i_stat.out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end
endmodule
`default_nettype wire

/* rtl/sll_dp.sv */
// Limiter datapath: gain stages, DC blocker, stores, divider, gain walk, output register.
`default_nettype none
module sll_dp #(
    parameter int DEPTH = sll_pkg::DELAY_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sll_pkg::t_cfg      i_cfg,
    input  sll_pkg::t_dp_cmd   i_cmd,
    input  sll_pkg::t_in_item  i_in_data,
    output sll_pkg::t_dp_stat  o_stat,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output sll_pkg::t_out_item o_out_data
);
    import sll_pkg::*;

    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW     = AW + 9;
    localparam int LA_MAX = (DEPTH - 1 > 255) ? 255 : DEPTH - 1;
    localparam int DW     = 2 * INT_BITS;

    // item payload registers
    t_in_item                    r_x;
    logic signed [INT_BITS-1:0]  r_chl, r_chr, r_leak_l, r_leak_r, r_dl, r_dr;
    logic [24:0]                 r_rise;
    logic [23:0]                 r_maybe;
    logic [31:0]                 r_peak;
    logic [55:0]                 r_prod;
    logic [31:0]                 r_rem;
    logic [DIV_BITS-1:0]         r_quo;
    logic [DIV_CNT_BITS-1:0]     r_dcnt;
    logic [23:0]                 r_cur, r_span, r_p, r_gold;
    logic [24:0]                 r_acc, r_a;
    logic [7:0]                  r_wi;
    t_out_item                   r_out;

    // block state
    logic [AW-1:0]               r_wp, r_clr;
    logic [GAIN_BITS-1:0]        r_last;
    logic signed [INT_BITS-1:0]  r_dc_in_l, r_dc_out_l, r_dc_in_r, r_dc_out_r;
    logic                        r_out_valid;

    logic                        linear, dc_on, out_free, less;
    logic [7:0]                  la_eff;
    logic [IW-1:0]               t_idx, t_rd;
    logic [AW-1:0]               idx, rd;
    logic signed [48:0]          m_pre_l, m_pre_r;
    logic signed [53:0]          m_leak_l, m_leak_r;
    logic [23:0]                 factor;
    logic [55:0]                 m_rise;
    logic [24:0]                 rise;
    logic [25:0]                 tot;
    logic signed [63:0]          s_l, s_r;
    logic signed [INT_BITS-1:0]  y_l, y_r;
    logic signed [56:0]          m_post_l, m_post_r, m_out_l, m_out_r;
    logic [31:0]                 mag_l, mag_r;
    logic [55:0]                 m_peak;
    logic [32:0]                 d_sh, d_sub;
    logic                        d_ge;
    logic [24:0]                 a_lin;
    logic [49:0]                 m_sq;
    logic [48:0]                 m_sp;
    logic [24:0]                 ng;
    logic [25:0]                 acc_sum;
    logic signed [INT_BITS-1:0]  rd_l, rd_r;

    // RAM ports
    logic                        g_we, d_we;
    logic [AW-1:0]               g_waddr, g_raddr, d_waddr;
    logic [GAIN_BITS-1:0]        g_wdata, g_rdata;
    logic [DW-1:0]               d_wdata, d_rdata;

    assign linear   = i_cfg.mode_bits[MODE_LINEAR];
    assign dc_on    = !i_cfg.mode_bits[MODE_DC_OFF];
    assign out_free = !r_out_valid || i_out_ready;
    assign la_eff   = (32'(i_cfg.lookahead) > LA_MAX) ? 8'(LA_MAX) : i_cfg.lookahead;

    // circular addresses: walk entry and read-out entry behind the write pointer
    always_comb begin
        t_idx = IW'(r_wp) - IW'(r_wi);
        if (t_idx[IW-1]) t_idx = t_idx + IW'(DEPTH);
        t_rd = IW'(r_wp) - IW'(la_eff);
        if (t_rd[IW-1]) t_rd = t_rd + IW'(DEPTH);
    end
    assign idx = t_idx[AW-1:0];
    assign rd  = t_rd[AW-1:0];

    // pre-gain, DC leak and recovery products
    assign m_pre_l  = $signed(r_x.left_in) * $signed({1'b0, i_cfg.preamp_gain});
    assign m_pre_r  = $signed(r_x.right_in) * $signed({1'b0, i_cfg.preamp_gain});
    assign m_leak_l = r_dc_out_l * $signed({1'b0, DC_LEAK});
    assign m_leak_r = r_dc_out_r * $signed({1'b0, DC_LEAK});
    assign factor   = (r_last > GAIN_FLOOR) ? r_last : UNITY_GAIN;
    assign m_rise   = i_cfg.recover_step * factor;

    always_comb begin
        if (linear) begin
            rise = 25'((33'(i_cfg.recover_step) + 33'd32768) >> 16);
        end else begin
            rise = 25'((57'(m_rise) + 57'd2147483648) >> 32);
        end
    end

    assign tot = 26'(r_rise) + 26'(r_last);

    // DC blocker
    assign s_l = 64'(r_chl) - 64'(r_dc_in_l) + 64'(r_dc_out_l) - 64'(r_leak_l);
    assign s_r = 64'(r_chr) - 64'(r_dc_in_r) + 64'(r_dc_out_r) - 64'(r_leak_r);
    assign y_l = sat_int(s_l);
    assign y_r = sat_int(s_r);

    // post-gain and peak
    assign m_post_l = r_chl * $signed({1'b0, i_cfg.postamp_gain});
    assign m_post_r = r_chr * $signed({1'b0, i_cfg.postamp_gain});
    assign mag_l    = r_chl[INT_BITS-1] ? (~r_chl + 32'd1) : r_chl;
    assign mag_r    = r_chr[INT_BITS-1] ? (~r_chr + 32'd1) : r_chr;
    assign m_peak   = r_peak * r_maybe;

    // restoring divider step
    assign d_sh  = {r_rem, r_quo[DIV_BITS-1]};
    assign d_ge  = d_sh >= {1'b0, r_peak};
    assign d_sub = d_sh - {1'b0, r_peak};

    // ramp position, squared for the quadratic curve
    assign a_lin   = (r_acc > RAMP_ONE) ? RAMP_ONE : r_acc;
    assign m_sq    = a_lin * a_lin;
    assign m_sp    = r_span * r_a;
    assign ng      = 25'(r_cur) + 25'(r_p);
    assign less    = ng < {1'b0, r_gold};
    assign acc_sum = 26'(r_acc) + 26'(i_cfg.recip_step);

    // output products
    assign rd_l     = d_rdata[DW-1:INT_BITS];
    assign rd_r     = d_rdata[INT_BITS-1:0];
    assign m_out_l  = rd_l * $signed({1'b0, g_rdata});
    assign m_out_r  = rd_r * $signed({1'b0, g_rdata});

    // RAM control
    always_comb begin
        g_we    = 1'b0;
        g_waddr = r_wp;
        g_wdata = r_maybe;
        d_we    = 1'b0;
        d_waddr = r_wp;
        d_wdata = {r_dl, r_dr};
        g_raddr = rd;
        unique case (i_cmd.op)
            OP_CLR: begin
                g_we    = 1'b1;
                g_waddr = r_clr;
                g_wdata = UNITY_GAIN;
                d_we    = 1'b1;
                d_waddr = r_clr;
                d_wdata = '0;
            end
            OP_GAIN: begin
                g_we = 1'b1;
                d_we = 1'b1;
            end
            OP_WA, OP_WB: g_raddr = idx;
            OP_WC: begin
                g_raddr = idx;
                g_we    = less;
                g_waddr = idx;
                g_wdata = ng[23:0];
            end
            OP_RDLAST: g_raddr = r_wp;
            default: ;
        endcase
    end

    sll_ram #(.WIDTH(GAIN_BITS), .DEPTH(DEPTH)) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (g_we),
        .i_waddr (g_waddr),
        .i_wdata (g_wdata),
        .i_raddr (g_raddr),
        .o_rdata (g_rdata)
    );

    sll_ram #(.WIDTH(DW), .DEPTH(DEPTH)) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (d_we),
        .i_waddr (d_waddr),
        .i_wdata (d_wdata),
        .i_raddr (rd),
        .o_rdata (d_rdata)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_x <= i_in_data;
        unique case (i_cmd.op)
            OP_PRE: begin
                r_chl    <= sat_int(rnd_shr16(64'(m_pre_l)));
                r_chr    <= sat_int(rnd_shr16(64'(m_pre_r)));
                r_leak_l <= INT_BITS'(rnd_shr32(64'(m_leak_l)));
                r_leak_r <= INT_BITS'(rnd_shr32(64'(m_leak_r)));
                r_rise   <= rise;
            end
            OP_DC: begin
                if (dc_on) begin
                    r_chl <= y_l;
                    r_chr <= y_r;
                end
                r_maybe <= (tot > 26'(i_cfg.threshold)) ? i_cfg.threshold : tot[23:0];
            end
            OP_POST: begin
                r_dl   <= sat_int(rnd_shr16(64'(m_post_l)));
                r_dr   <= sat_int(rnd_shr16(64'(m_post_r)));
                r_peak <= (mag_r > mag_l) ? mag_r : mag_l;
            end
            OP_GAIN: r_prod <= m_peak;
            OP_TEST: begin
                r_rem  <= '0;
                r_quo  <= {i_cfg.threshold, {(SAMPLE_BITS-1){1'b0}}};
                r_dcnt <= '0;
                r_wi   <= '0;
                r_acc  <= '0;
            end
            OP_DIV: begin
                r_rem  <= d_ge ? d_sub[31:0] : d_sh[31:0];
                r_quo  <= {r_quo[DIV_BITS-2:0], d_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end
            OP_SPAN: begin
                r_cur  <= r_quo[23:0];
                r_span <= i_cfg.threshold - r_quo[23:0];
            end
            OP_WA: r_a <= linear ? a_lin : 25'(m_sq >> 24);
            OP_WB: begin
                r_p    <= 24'(m_sp >> 24);
                r_gold <= g_rdata;
            end
            OP_WC: begin
                r_wi  <= r_wi + 1'b1;
                r_acc <= (acc_sum > 26'(RAMP_ONE)) ? (RAMP_ONE + 25'd1) : acc_sum[24:0];
            end
            OP_MULOUT: begin
                if (out_free) begin
                    r_out.left_out     <= sat_smp(rnd_shr16(64'(m_out_l)));
                    r_out.right_out    <= sat_smp(rnd_shr16(64'(m_out_r)));
                    r_out.applied_gain <= g_rdata;
                end
            end
            OP_BYP: begin
                if (out_free) begin
                    if (i_cfg.mode_bits[MODE_MUTE]) begin
                        r_out <= '0;
                    end else begin
                        r_out.left_out     <= r_x.left_in;
                        r_out.right_out    <= r_x.right_in;
                        r_out.applied_gain <= UNITY_GAIN;
                    end
                end
            end
            default: ;
        endcase
    end

    // block state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp        <= '0;
            r_clr       <= '0;
            r_last      <= UNITY_GAIN;
            r_dc_in_l   <= '0;
            r_dc_out_l  <= '0;
            r_dc_in_r   <= '0;
            r_dc_out_r  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // load a new result, else drop the one just transferred
            if ((i_cmd.op == OP_MULOUT || i_cmd.op == OP_BYP) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_CLR: r_clr <= r_clr + 1'b1;
                OP_DC: begin
                    if (dc_on) begin
                        r_dc_in_l  <= r_chl;
                        r_dc_out_l <= y_l;
                        r_dc_in_r  <= r_chr;
                        r_dc_out_r <= y_r;
                    end
                end
                OP_RDOUT: r_last <= g_rdata;
                OP_MULOUT: begin
                    if (out_free) begin
                        r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_stat.mute     = i_cfg.mode_bits[MODE_MUTE];
    assign o_stat.bypass   = i_cfg.mode_bits[MODE_BYPASS];
    assign o_stat.trigger  = r_prod > 56'({i_cfg.threshold, {(SAMPLE_BITS-1){1'b0}}});
    assign o_stat.walk_on  = la_eff != 8'd0;
    assign o_stat.div_last = r_dcnt == DIV_CNT_BITS'(DIV_BITS - 1);
    assign o_stat.walk_end = !less || (9'(r_wi) + 9'd1 == 9'(la_eff));
    assign o_stat.clr_last = r_clr == AW'(DEPTH - 1);
    assign o_stat.out_free = out_free;
endmodule
`default_nettype wire
